// File: design/vmqt_pkg.sv
// Shared types and constants of the vector, matrix and quaternion transform block.
`default_nettype none

package vmqt_pkg;

	localparam int COMP_W     = 32;
	localparam int QUAT_W     = 16;
	localparam int COEF_W     = 35;
	localparam int ROT_FRAC   = 28;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int LAST_STAGE = 6;
	localparam int SETTLE     = 3;

	localparam logic [CFG_W-1:0] QUAT_RESET  = 64'd16384;
	localparam logic [2:0]       COUNT_RESET = 3'd3;
	localparam logic [2:0]       COUNT_MIN   = 3'd2;
	localparam logic [2:0]       COUNT_MAX   = 3'd4;

	// One in Q.28, the common coefficient format
	localparam logic [COEF_W-1:0] ROT_ONE = COEF_W'(1) << ROT_FRAC;

	localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
	localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_POINT     = 2'd0,
		MODE_DIRECTION = 2'd1,
		MODE_QUAT      = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_COUNT     = 3'd1,
		REG_ROW_ONE   = 3'd2,
		REG_ROW_TWO   = 3'd3,
		REG_ROW_THREE = 3'd4,
		REG_ROW_FOUR  = 3'd5,
		REG_QUAT      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] in_x;
		logic signed [COMP_W-1:0] in_y;
		logic signed [COMP_W-1:0] in_z;
		logic signed [COMP_W-1:0] in_w;
		logic                     final_item;
	} vec_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] out_x;
		logic signed [COMP_W-1:0] out_y;
		logic signed [COMP_W-1:0] out_z;
		logic signed [COMP_W-1:0] out_w;
		logic                     saturated_flag;
		logic                     final_result;
	} res_t;

	typedef logic [COMP_W-1:0] comp_t;
	typedef comp_t [3:0]       vec4_t;
	typedef logic [COEF_W-1:0] coef_t;
	typedef coef_t [3:0]       coef_col_t;
	typedef coef_col_t [3:0]   coef_mat_t;
	typedef logic [LAST_STAGE:2] lane_en_t;

	typedef struct packed {
		logic       quat;
		logic       direction;
		logic [2:0] count;
		logic       settled;
	} ctrl_t;

endpackage

`default_nettype wire

// File: design/vmqt_coef.sv
// Configuration registers and the coefficient matrix derived from them.
`default_nettype none

module vmqt_coef #(
	parameter int COEFF_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [vmqt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vmqt_pkg::CFG_W-1:0]        cfg_data,
	output vmqt_pkg::ctrl_t                        ctrl,
	output vmqt_pkg::coef_mat_t                    coef
);

	localparam int MAT_SHIFT = vmqt_pkg::ROT_FRAC - (COEFF_WIDTH - 4);
	localparam int ROW_W = (4 * COEFF_WIDTH > vmqt_pkg::CFG_W) ? 4 * COEFF_WIDTH : vmqt_pkg::CFG_W;
	localparam int QW = vmqt_pkg::QUAT_W;
	localparam int QP_W = 2 * QW;

	logic [1:0]                  mode_q;
	logic [2:0]                  count_q;
	logic [vmqt_pkg::CFG_W-1:0]  row_q [4];
	logic [vmqt_pkg::CFG_W-1:0]  quat_q;
	logic [1:0]                  settle_q;

	logic signed [QW-1:0]   qx, qy, qz, qw;
	logic signed [QP_W-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
	vmqt_pkg::coef_t        rot_q [3][3];
	vmqt_pkg::coef_mat_t    coef_q;
	vmqt_pkg::coef_mat_t    mat;
	logic [ROW_W-1:0]       rowx [4];

	function automatic vmqt_pkg::coef_t ext(input logic signed [QP_W-1:0] a);
		return vmqt_pkg::COEF_W'(a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= vmqt_pkg::MODE_POINT;
			count_q  <= vmqt_pkg::COUNT_RESET;
			row_q    <= '{default: '0};
			quat_q   <= vmqt_pkg::QUAT_RESET;
			settle_q <= 2'(vmqt_pkg::SETTLE);
		end else if (cfg_valid) begin
			// refill the coefficient stages after any write
			settle_q <= 2'(vmqt_pkg::SETTLE);
			unique case (cfg_index)
				vmqt_pkg::REG_MODE:      mode_q   <= cfg_data[1:0];
				vmqt_pkg::REG_COUNT:     count_q  <= cfg_data[2:0];
				vmqt_pkg::REG_ROW_ONE:   row_q[0] <= cfg_data;
				vmqt_pkg::REG_ROW_TWO:   row_q[1] <= cfg_data;
				vmqt_pkg::REG_ROW_THREE: row_q[2] <= cfg_data;
				vmqt_pkg::REG_ROW_FOUR:  row_q[3] <= cfg_data;
				vmqt_pkg::REG_QUAT:      quat_q   <= cfg_data;
				default: ;
			endcase
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	assign qx = quat_q[3*QW +: QW];
	assign qy = quat_q[2*QW +: QW];
	assign qz = quat_q[QW +: QW];
	assign qw = quat_q[0 +: QW];

	always_ff @(posedge clk) begin
		xx_q <= qx * qx;
		yy_q <= qy * qy;
		zz_q <= qz * qz;
		xy_q <= qx * qy;
		xz_q <= qx * qz;
		yz_q <= qy * qz;
		wx_q <= qw * qx;
		wy_q <= qw * qy;
		wz_q <= qw * qz;
	end

	// Rotation matrix in Q.28, row j produces output component j
	always_ff @(posedge clk) begin
		rot_q[0][0] <= vmqt_pkg::ROT_ONE - ((ext(yy_q) + ext(zz_q)) << 1);
		rot_q[0][1] <= (ext(xy_q) - ext(wz_q)) << 1;
		rot_q[0][2] <= (ext(xz_q) + ext(wy_q)) << 1;
		rot_q[1][0] <= (ext(xy_q) + ext(wz_q)) << 1;
		rot_q[1][1] <= vmqt_pkg::ROT_ONE - ((ext(xx_q) + ext(zz_q)) << 1);
		rot_q[1][2] <= (ext(yz_q) - ext(wx_q)) << 1;
		rot_q[2][0] <= (ext(xz_q) - ext(wy_q)) << 1;
		rot_q[2][1] <= (ext(yz_q) + ext(wx_q)) << 1;
		rot_q[2][2] <= vmqt_pkg::ROT_ONE - ((ext(xx_q) + ext(yy_q)) << 1);
	end

	// Matrix coefficients rescaled to Q.28; bits above the register read as zero
	for (genvar i = 0; i < 4; i++) begin : g_row
		assign rowx[i] = ROW_W'(row_q[i]);
		for (genvar j = 0; j < 4; j++) begin : g_col
			assign mat[j][i] = vmqt_pkg::COEF_W'(
				$signed(rowx[i][(3-j)*COEFF_WIDTH +: COEFF_WIDTH])) << MAT_SHIFT;
		end
	end

	// Quaternion mode passes w through lane four as w times one
	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			for (int i = 0; i < 4; i++) begin
				if (ctrl.quat) begin
					if (i < 3 && j < 3)
						coef_q[j][i] <= rot_q[j][i];
					else if (i == 3 && j == 3)
						coef_q[j][i] <= vmqt_pkg::ROT_ONE;
					else
						coef_q[j][i] <= '0;
				end else begin
					coef_q[j][i] <= mat[j][i];
				end
			end
		end
	end

	assign coef = coef_q;

	always_comb begin
		ctrl.quat      = (mode_q & vmqt_pkg::MODE_QUAT) != 2'd0;
		ctrl.direction = (mode_q == vmqt_pkg::MODE_DIRECTION);
		if (count_q < vmqt_pkg::COUNT_MIN)
			ctrl.count = vmqt_pkg::COUNT_MIN;
		else if (count_q > vmqt_pkg::COUNT_MAX)
			ctrl.count = vmqt_pkg::COUNT_MAX;
		else
			ctrl.count = count_q;
		ctrl.settled   = (settle_q == 2'd0);
	end

	a_write_unsettles: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> !ctrl.settled)
		else $error("coefficients reported settled right after a register write");

	a_quat_w_identity: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.settled && ctrl.quat |-> coef_q[3][3] == vmqt_pkg::ROT_ONE
			&& coef_q[0][3] == '0 && coef_q[3][0] == '0)
		else $error("quaternion coefficients not in place once settled");

endmodule

`default_nettype wire

// File: design/vmqt_lane.sv
// One output lane: four products, adder tree, rounding and saturation.
`default_nettype none

module vmqt_lane (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire vmqt_pkg::lane_en_t   en,
	input  wire vmqt_pkg::vec4_t      v_s1,
	input  wire logic                 keep_s1,
	input  wire vmqt_pkg::coef_col_t  coef,
	output vmqt_pkg::comp_t           res,
	output logic                      sat
);

	localparam int CW  = vmqt_pkg::COMP_W;
	localparam int KW  = vmqt_pkg::COEF_W;
	localparam int H   = CW / 2;
	localparam int PLW = H + 1 + KW;
	localparam int PHW = (CW - H) + KW;
	localparam int PW  = CW + KW;
	localparam int AW  = PW + 2;
	localparam int QW  = AW - vmqt_pkg::ROT_FRAC;
	localparam logic [AW-1:0] HALF = AW'(1) << (vmqt_pkg::ROT_FRAC - 1);

	logic signed [PLW-1:0] pl_s2 [4];
	logic signed [PHW-1:0] ph_s2 [4];
	logic signed [PW-1:0]  p_s3  [4];
	logic signed [PW:0]    s01_s4, s23_s4;
	logic signed [AW-1:0]  acc_s5;
	logic                  keep_s2, keep_s3, keep_s4, keep_s5, keep_s6;
	vmqt_pkg::comp_t       res_s6;
	logic                  sat_s6;

	logic [AW-1:0]   rnd;
	logic [QW-1:0]   rq;
	logic            fits;
	vmqt_pkg::comp_t clamped;

	// Split each component so no multiplier exceeds half a component by a coefficient
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 4; i++) begin
				pl_s2[i] <= $signed({1'b0, v_s1[i][H-1:0]}) * $signed(coef[i]);
				ph_s2[i] <= $signed(v_s1[i][CW-1:H]) * $signed(coef[i]);
			end
		end
		if (en[3]) begin
			for (int i = 0; i < 4; i++)
				p_s3[i] <= (PW'(ph_s2[i]) <<< H) + PW'(pl_s2[i]);
		end
		if (en[4]) begin
			s01_s4 <= (PW+1)'(p_s3[0]) + (PW+1)'(p_s3[1]);
			s23_s4 <= (PW+1)'(p_s3[2]) + (PW+1)'(p_s3[3]);
		end
		if (en[5])
			acc_s5 <= AW'(s01_s4) + AW'(s23_s4);
	end

	// Round half up at 28 fraction bits, then clamp
	always_comb begin
		rnd     = acc_s5 + HALF;
		rq      = rnd[AW-1:vmqt_pkg::ROT_FRAC];
		fits    = (&rq[QW-1:CW-1]) || !(|rq[QW-1:CW-1]);
		clamped = rq[QW-1] ? vmqt_pkg::COMP_MIN : vmqt_pkg::COMP_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_s2 <= 1'b0;
			keep_s3 <= 1'b0;
			keep_s4 <= 1'b0;
			keep_s5 <= 1'b0;
			keep_s6 <= 1'b0;
			res_s6  <= '0;
			sat_s6  <= 1'b0;
		end else begin
			if (en[2]) keep_s2 <= keep_s1;
			if (en[3]) keep_s3 <= keep_s2;
			if (en[4]) keep_s4 <= keep_s3;
			if (en[5]) keep_s5 <= keep_s4;
			if (en[6]) begin
				keep_s6 <= keep_s5;
				res_s6  <= keep_s5 ? (fits ? rq[CW-1:0] : clamped) : '0;
				sat_s6  <= keep_s5 && !fits;
			end
		end
	end

	assign res = res_s6;
	assign sat = sat_s6;

	a_sat_is_limit: assert property (@(posedge clk) disable iff (!arst_n)
		sat_s6 |-> keep_s6 && (res_s6 == vmqt_pkg::COMP_MAX || res_s6 == vmqt_pkg::COMP_MIN))
		else $error("saturation flagged on a lane value that is not a limit");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!keep_s6 |-> res_s6 == '0 && !sat_s6)
		else $error("unused lane produced a nonzero result");

endmodule

`default_nettype wire

// File: design/vector_matrix_quaternion_transform_core.sv
// Top level of the vertex transform: input select, valid pipeline and four lanes.
//
// Usage. Vectors enter on the vec channel (valid/ready, payload vec_data) and
// transformed vectors leave on the res channel (valid/ready, payload res_data).
// Registers are written through the cfg channel (cfg_index, cfg_data); cfg_ready
// is always high. Write registers only while no vector is in flight.
// Pipeline: an accepted vector passes six register stages: operand select,
// split multiply, product merge, pair sums, final sum, round and saturate
// into the output register, which drives res.
// Throughput: one vector per cycle when not stalled, set by the four fully
// pipelined lanes, each with eight half-width multipliers.
// Reset and configuration: after reset, and after every register write,
// vec_ready stays low while the quaternion products, the rotation matrix
// and the selected coefficient matrix refill.
// Stalls: when res_ready is low the output register holds its result and
// each stage holds only while the stage after it is full, so empty stages
// keep filling; nothing is dropped or repeated.
`default_nettype none

module vector_matrix_quaternion_transform_core #(
	parameter int COEFF_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           vec_valid,
	output logic                                vec_ready,
	input  wire vmqt_pkg::vec_t                 vec_data,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output vmqt_pkg::res_t                      res_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [vmqt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vmqt_pkg::CFG_W-1:0]     cfg_data
);

	localparam vmqt_pkg::comp_t ONE_COMP = vmqt_pkg::COMP_W'(1) << (vmqt_pkg::COMP_W / 2);

	vmqt_pkg::ctrl_t     ctrl;
	vmqt_pkg::coef_mat_t coef;

	logic [vmqt_pkg::LAST_STAGE:1] en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic final_s1, final_s2, final_s3, final_s4, final_s5, final_s6;

	vmqt_pkg::vec4_t v_in;
	logic [3:0]      keep_in;
	vmqt_pkg::vec4_t v_s1;
	logic [3:0]      keep_s1;

	vmqt_pkg::comp_t lane_res [4];
	logic [3:0]      lane_sat;

	vmqt_coef #(
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.coef      (coef)
	);

	assign cfg_ready = 1'b1;

	// A stage advances when it is empty or the stage after it advances
	always_comb begin
		en[6] = !valid_s6 || res_ready;
		en[5] = !valid_s5 || en[6];
		en[4] = !valid_s4 || en[5];
		en[3] = !valid_s3 || en[4];
		en[2] = !valid_s2 || en[3];
		en[1] = !valid_s1 || en[2];
	end

	assign vec_ready = en[1] && ctrl.settled;

	// Fourth operand: w, the implied 1.0 of a point, or zero for a direction
	always_comb begin
		v_in[0] = vec_data.in_x;
		v_in[1] = vec_data.in_y;
		v_in[2] = (ctrl.count >= 3'd3) ? vec_data.in_z : '0;
		if (ctrl.quat || (!ctrl.direction && ctrl.count == 3'd4))
			v_in[3] = vec_data.in_w;
		else if (ctrl.direction)
			v_in[3] = '0;
		else
			v_in[3] = ONE_COMP;
		for (int j = 0; j < 4; j++)
			keep_in[j] = 3'(j) < ctrl.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en[1]) valid_s1 <= vec_valid && vec_ready;
			if (en[2]) valid_s2 <= valid_s1;
			if (en[3]) valid_s3 <= valid_s2;
			if (en[4]) valid_s4 <= valid_s3;
			if (en[5]) valid_s5 <= valid_s4;
			if (en[6]) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			v_s1     <= v_in;
			keep_s1  <= keep_in;
			final_s1 <= vec_data.final_item;
		end
		if (en[2]) final_s2 <= final_s1;
		if (en[3]) final_s3 <= final_s2;
		if (en[4]) final_s4 <= final_s3;
		if (en[5]) final_s5 <= final_s4;
		if (en[6]) final_s6 <= final_s5;
	end

	for (genvar j = 0; j < 4; j++) begin : g_lane
		vmqt_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en[vmqt_pkg::LAST_STAGE:2]),
			.v_s1    (v_s1),
			.keep_s1 (keep_s1[j]),
			.coef    (coef[j]),
			.res     (lane_res[j]),
			.sat     (lane_sat[j])
		);
	end

	assign res_valid = valid_s6;

	always_comb begin
		res_data.out_x          = lane_res[0];
		res_data.out_y          = lane_res[1];
		res_data.out_z          = lane_res[2];
		res_data.out_w          = lane_res[3];
		res_data.saturated_flag = |lane_sat;
		res_data.final_result   = final_s6;
	end

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> !vec_ready)
		else $error("vector transfer possible before coefficients refilled");

	a_sat_flag_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.saturated_flag |->
			res_data.out_x == vmqt_pkg::COMP_MAX || res_data.out_x == vmqt_pkg::COMP_MIN ||
			res_data.out_y == vmqt_pkg::COMP_MAX || res_data.out_y == vmqt_pkg::COMP_MIN ||
			res_data.out_z == vmqt_pkg::COMP_MAX || res_data.out_z == vmqt_pkg::COMP_MIN ||
			res_data.out_w == vmqt_pkg::COMP_MAX || res_data.out_w == vmqt_pkg::COMP_MIN)
		else $error("saturated result without any component at a limit");

endmodule

`default_nettype wire

// File: verif/vmqt_result_checker.sv
// Checker for the vertex transform: tracks register writes, predicts each result and compares.
module vmqt_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vec_valid,
	input  logic                           vec_ready,
	input  vmqt_pkg::vec_t                 vec_data,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  vmqt_pkg::res_t                 res_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [vmqt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vmqt_pkg::CFG_W-1:0]     cfg_data,
	output int                             mismatch_count,
	output int                             results_outstanding
);
	import vmqt_pkg::*;

	localparam int COEF_BITS = 16;
	localparam logic signed [127:0] COMP_HI = 128'sd2147483647;
	localparam logic signed [127:0] COMP_LO = -128'sd2147483648;
	localparam logic signed [127:0] Q16_UNIT = 128'sd1 <<< (COMP_W / 2);
	localparam logic signed [127:0] ROT_UNIT = 128'sd1 <<< ROT_FRAC;

	logic [1:0]            mode_q;
	logic [2:0]            count_q;
	logic [3:0][CFG_W-1:0] rows_q;
	logic [CFG_W-1:0]      quat_q;
	res_t                  predicted_results[$];

	// Round half up at frac bits, then clamp; bit 32 flags a clamp.
	function automatic logic [32:0] round_clamp(input logic signed [127:0] acc, input int frac);
		logic signed [127:0] r;
		r = (acc + (128'sd1 <<< (frac - 1))) >>> frac;
		if (r > COMP_HI)
			return {1'b1, COMP_MAX};
		if (r < COMP_LO)
			return {1'b1, COMP_MIN};
		return {1'b0, r[31:0]};
	endfunction

	function automatic res_t transform_vector(input vec_t v);
		logic signed [127:0] comp [0:3];
		logic signed [127:0] rot [0:2][0:2];
		logic signed [127:0] acc, qx, qy, qz, qw;
		logic [32:0]         rounded;
		comp_t               outc [0:3];
		logic                sat;
		int                  n, i, j;
		res_t                o;
		n = count_q < 2 ? 2 : (count_q > 4 ? 4 : int'(count_q));
		sat = 1'b0;
		for (j = 0; j < 4; j++)
			outc[j] = '0;
		comp[0] = $signed(v.in_x);
		comp[1] = $signed(v.in_y);
		comp[2] = $signed(v.in_z);
		comp[3] = $signed(v.in_w);
		if (n < 3)
			comp[2] = 0;
		if (!mode_q[1]) begin
			if (mode_q == MODE_DIRECTION)
				comp[3] = 0;
			else if (n < 4)
				comp[3] = Q16_UNIT;
			for (j = 0; j < n; j++) begin
				acc = 0;
				for (i = 0; i < 4; i++)
					acc = acc + comp[i] * $signed(rows_q[i][(3 - j) * COEF_BITS +: COEF_BITS]);
				rounded = round_clamp(acc, COEF_BITS - 4);
				outc[j] = rounded[31:0];
				sat = sat | rounded[32];
			end
		end else begin
			qx = $signed(quat_q[63:48]);
			qy = $signed(quat_q[47:32]);
			qz = $signed(quat_q[31:16]);
			qw = $signed(quat_q[15:0]);
			rot[0][0] = ROT_UNIT - 2 * (qy * qy + qz * qz);
			rot[0][1] = 2 * (qx * qy - qw * qz);
			rot[0][2] = 2 * (qx * qz + qw * qy);
			rot[1][0] = 2 * (qx * qy + qw * qz);
			rot[1][1] = ROT_UNIT - 2 * (qx * qx + qz * qz);
			rot[1][2] = 2 * (qy * qz - qw * qx);
			rot[2][0] = 2 * (qx * qz - qw * qy);
			rot[2][1] = 2 * (qy * qz + qw * qx);
			rot[2][2] = ROT_UNIT - 2 * (qx * qx + qy * qy);
			for (j = 0; j < 3 && j < n; j++) begin
				acc = 0;
				for (i = 0; i < 3; i++)
					acc = acc + comp[i] * rot[j][i];
				rounded = round_clamp(acc, ROT_FRAC);
				outc[j] = rounded[31:0];
				sat = sat | rounded[32];
			end
			// w passes straight through
			if (n == 4)
				outc[3] = v.in_w;
		end
		o.out_x          = outc[0];
		o.out_y          = outc[1];
		o.out_z          = outc[2];
		o.out_w          = outc[3];
		o.saturated_flag = sat;
		o.final_result   = v.final_item;
		return o;
	endfunction

	function automatic int check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		int   errs;
		if (!arst_n) begin
			mode_q              <= MODE_POINT;
			count_q             <= COUNT_RESET;
			rows_q              <= '0;
			quat_q              <= QUAT_RESET;
			mismatch_count      <= 0;
			results_outstanding <= 0;
			predicted_results.delete();
		end else begin
			errs = 0;
			if (res_valid && res_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, res_data);
					errs = 1;
				end else begin
					want = predicted_results.pop_front();
					errs = check_field("out_x", want.out_x, res_data.out_x)
						+ check_field("out_y", want.out_y, res_data.out_y)
						+ check_field("out_z", want.out_z, res_data.out_z)
						+ check_field("out_w", want.out_w, res_data.out_w)
						+ check_field("saturated_flag", want.saturated_flag, res_data.saturated_flag)
						+ check_field("final_result", want.final_result, res_data.final_result);
				end
			end
			if (vec_valid && vec_ready)
				predicted_results.push_back(transform_vector(vec_data));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:      mode_q    <= cfg_data[1:0];
					REG_COUNT:     count_q   <= cfg_data[2:0];
					REG_ROW_ONE:   rows_q[0] <= cfg_data;
					REG_ROW_TWO:   rows_q[1] <= cfg_data;
					REG_ROW_THREE: rows_q[2] <= cfg_data;
					REG_ROW_FOUR:  rows_q[3] <= cfg_data;
					REG_QUAT:      quat_q    <= cfg_data;
					default: ;
				endcase
			end
			mismatch_count      <= mismatch_count + errs;
			results_outstanding <= predicted_results.size();
		end
	end

endmodule

// File: verif/tb_vector_matrix_quaternion_transform_core.sv
// Testbench top for the vertex transform: clock, reset, register setup, vector stimulus, verdict.
module tb_vector_matrix_quaternion_transform_core;
	import vmqt_pkg::*;

	localparam int ITEM_TARGET  = 450;
	localparam int DRAIN_CYCLES = 16;
	localparam int RUN_LIMIT    = 3000000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
	localparam logic [1:0]           MODE_SPARE = 2'd3;

	localparam logic [15:0] C_ONE     = 16'h1000;
	localparam logic [15:0] C_NEG_ONE = 16'hF000;
	localparam logic [15:0] C_MAX     = 16'h7FFF;
	localparam logic [15:0] C_MIN     = 16'h8000;
	localparam logic [15:0] C_ZERO    = 16'h0000;

	localparam logic [63:0] ROW_ID_ONE   = {C_ONE, C_ZERO, C_ZERO, C_ZERO};
	localparam logic [63:0] ROW_ID_TWO   = {C_ZERO, C_ONE, C_ZERO, C_ZERO};
	localparam logic [63:0] ROW_ID_THREE = {C_ZERO, C_ZERO, C_ONE, C_ZERO};
	localparam logic [63:0] ROW_SHIFT    = {16'h2000, 16'hE000, 16'h0800, C_ONE};
	localparam logic [63:0] ROW_ALL_MAX  = {4{C_MAX}};
	localparam logic [63:0] ROW_ALL_MIN  = {4{C_MIN}};

	localparam logic [63:0] QUAT_TURN_Z   = {16'h0000, 16'h0000, 16'h2D41, 16'h2D41};
	localparam logic [63:0] QUAT_HALF_X   = {16'h4000, 16'h0000, 16'h0000, 16'h0000};
	localparam logic [63:0] QUAT_DIAG     = {4{16'h2000}};
	localparam logic [63:0] QUAT_EXTREMES = {C_MAX, C_MIN, C_MAX, C_MIN};

	localparam comp_t V_ONE = 32'h0001_0000;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 vec_valid   = 1'b0;
	vec_t                 vec_data    = '0;
	logic                 res_ready   = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;
	logic                 vec_ready;
	logic                 res_valid;
	res_t                 res_data;
	logic                 cfg_ready;
	int                   mismatch_count;
	int                   results_outstanding;
	int                   tx_idle_pct = 30;
	int                   rx_idle_pct = 30;

	always #6 clk = ~clk;

	vector_matrix_quaternion_transform_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_valid (vec_valid),
		.vec_ready (vec_ready),
		.vec_data  (vec_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	vmqt_result_checker u_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.vec_valid           (vec_valid),
		.vec_ready           (vec_ready),
		.vec_data            (vec_data),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.res_data            (res_data),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.mismatch_count      (mismatch_count),
		.results_outstanding (results_outstanding)
	);

	function automatic int draw_gap(input int pct);
		if ($urandom_range(0, 99) < pct)
			return $urandom_range(1, 12);
		return 0;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 20;
			2: return 50;
			default: return 90;
		endcase
	endfunction

	function automatic comp_t rand_comp();
		case ($urandom_range(0, 9))
			0: return COMP_MAX;
			1: return COMP_MIN;
			2: return '0;
			3: return '1;
			4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return C_MAX;
			1: return C_MIN;
			2: return C_ZERO;
			3: return C_ONE;
			4: return C_NEG_ONE;
			5, 6: return 16'($urandom_range(0, 16'h2000) - 16'h1000);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_row();
		return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
	endfunction

	function automatic logic [63:0] rand_quat();
		case ($urandom_range(0, 5))
			0: return QUAT_RESET;
			1: return QUAT_TURN_Z;
			2: return QUAT_HALF_X;
			3: return QUAT_DIAG;
			4: return {$urandom, $urandom};
			default: return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
		endcase
	endfunction

	function automatic vec_t make_vec(input comp_t x, input comp_t y, input comp_t z,
		input comp_t w, input logic fin);
		vec_t v;
		v.in_x       = x;
		v.in_y       = y;
		v.in_z       = z;
		v.in_w       = w;
		v.final_item = fin;
		return v;
	endfunction

	function automatic vec_t random_vec();
		return make_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
			$urandom_range(0, 7) == 0);
	endfunction

	// Leaves vec_valid high after the transfer; the caller drops it at the end of a burst.
	task automatic send_vec(input vec_t v);
		int gap;
		gap = draw_gap(tx_idle_pct);
		if (gap > 0) begin
			vec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vec_valid <= 1'b1;
		vec_data  <= v;
		do @(posedge clk); while (!(vec_valid && vec_ready));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	// Wait for every result, then rewrite all registers.
	task automatic load_config(input logic [1:0] mode, input logic [2:0] count,
		input logic [63:0] r1, input logic [63:0] r2, input logic [63:0] r3,
		input logic [63:0] r4, input logic [63:0] quat, input logic poke_spare);
		do @(posedge clk); while (results_outstanding != 0);
		write_reg(REG_MODE, 64'(mode));
		write_reg(REG_COUNT, 64'(count));
		write_reg(REG_ROW_ONE, r1);
		write_reg(REG_ROW_TWO, r2);
		write_reg(REG_ROW_THREE, r3);
		write_reg(REG_ROW_FOUR, r4);
		write_reg(REG_QUAT, quat);
		if (poke_spare)
			write_reg(REG_SPARE, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = draw_gap(rx_idle_pct);
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
		end
	end

	initial begin
		#RUN_LIMIT;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int sent;
		int burst;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Registers at their reset values: zero matrix, point mode, three components
		send_vec(make_vec(V_ONE, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1'b1));
		vec_valid <= 1'b0;

		load_config(MODE_POINT, 3'd3, ROW_ID_ONE, ROW_ID_TWO, ROW_ID_THREE, ROW_SHIFT,
			QUAT_RESET, 1'b0);
		send_vec(make_vec(COMP_MAX, COMP_MIN, '0, '1, 1'b0));
		send_vec(make_vec(COMP_MIN, COMP_MAX, '1, COMP_MAX, 1'b1));
		send_vec(make_vec('0, '0, '0, '0, 1'b0));
		send_vec(make_vec('1, '1, '1, '1, 1'b1));
		vec_valid <= 1'b0;

		load_config(MODE_POINT, 3'd4, ROW_ID_ONE, ROW_ID_TWO, ROW_ID_THREE, ROW_SHIFT,
			QUAT_RESET, 1'b0);
		send_vec(make_vec(V_ONE, 32'h0002_0000, 32'h0003_0000, 32'h0000_8000, 1'b0));
		send_vec(make_vec(rand_comp(), rand_comp(), rand_comp(), COMP_MIN, 1'b1));
		vec_valid <= 1'b0;

		load_config(MODE_DIRECTION, 3'd4, rand_row(), rand_row(), rand_row(), ROW_SHIFT,
			QUAT_RESET, 1'b0);
		send_vec(make_vec(V_ONE, '1, COMP_MAX, COMP_MAX, 1'b0));
		send_vec(random_vec());
		vec_valid <= 1'b0;

		load_config(MODE_POINT, 3'd2, rand_row(), rand_row(), rand_row(), ROW_SHIFT,
			QUAT_RESET, 1'b0);
		send_vec(make_vec(V_ONE, '1, COMP_MAX, COMP_MIN, 1'b1));
		vec_valid <= 1'b0;
		load_config(MODE_POINT, 3'd0, ROW_ALL_MAX, ROW_ALL_MIN, ROW_ID_THREE, ROW_SHIFT,
			QUAT_RESET, 1'b0);
		send_vec(make_vec(COMP_MAX, V_ONE, COMP_MAX, COMP_MAX, 1'b0));
		vec_valid <= 1'b0;

		// Saturation at both limits
		load_config(MODE_POINT, 3'd7, ROW_ALL_MAX, ROW_ALL_MAX, ROW_ALL_MAX, ROW_ALL_MAX,
			QUAT_RESET, 1'b0);
		send_vec(make_vec(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 1'b0));
		send_vec(make_vec(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 1'b1));
		vec_valid <= 1'b0;
		load_config(MODE_DIRECTION, 3'd5, ROW_ALL_MIN, ROW_ALL_MIN, ROW_ALL_MIN, ROW_ALL_MIN,
			QUAT_RESET, 1'b0);
		send_vec(make_vec(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MAX, 1'b0));
		vec_valid <= 1'b0;

		load_config(MODE_QUAT, 3'd4, rand_row(), rand_row(), rand_row(), rand_row(),
			QUAT_RESET, 1'b0);
		send_vec(make_vec(V_ONE, COMP_MIN, COMP_MAX, COMP_MIN, 1'b1));
		vec_valid <= 1'b0;
		load_config(MODE_QUAT, 3'd3, rand_row(), rand_row(), rand_row(), rand_row(),
			QUAT_TURN_Z, 1'b0);
		send_vec(make_vec(V_ONE, 32'h0002_0000, 32'h0003_0000, '0, 1'b0));
		send_vec(make_vec(COMP_MAX, COMP_MIN, '1, COMP_MAX, 1'b1));
		vec_valid <= 1'b0;

		// Mode 3 with a non-unit quaternion
		load_config(MODE_SPARE, 3'd4, rand_row(), rand_row(), rand_row(), rand_row(),
			QUAT_EXTREMES, 1'b0);
		send_vec(make_vec(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 1'b0));
		send_vec(make_vec(COMP_MIN, V_ONE, COMP_MIN, '1, 1'b1));
		vec_valid <= 1'b0;

		load_config(MODE_QUAT, 3'd2, rand_row(), rand_row(), rand_row(), rand_row(),
			QUAT_HALF_X, 1'b1);
		send_vec(make_vec(V_ONE, COMP_MAX, COMP_MAX, COMP_MAX, 1'b0));
		vec_valid <= 1'b0;
		load_config(MODE_QUAT, 3'd1, rand_row(), rand_row(), rand_row(), rand_row(),
			QUAT_DIAG, 1'b0);
		send_vec(make_vec(COMP_MIN, V_ONE, COMP_MAX, COMP_MAX, 1'b1));
		vec_valid <= 1'b0;

		while (sent < ITEM_TARGET) begin
			load_config(2'($urandom_range(0, 3)),
				($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 4)),
				rand_row(), rand_row(), rand_row(), rand_row(), rand_quat(),
				$urandom_range(0, 9) == 0);
			tx_idle_pct = pick_pct();
			rx_idle_pct = pick_pct();
			burst = $urandom_range(15, 45);
			repeat (burst) send_vec(random_vec());
			vec_valid <= 1'b0;
			sent += burst;
		end

		do @(posedge clk); while (results_outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
design/vmqt_pkg.sv
design/vmqt_coef.sv
design/vmqt_lane.sv
design/vector_matrix_quaternion_transform_core.sv
verif/vmqt_result_checker.sv
verif/tb_vector_matrix_quaternion_transform_core.sv
